// ===== design/rewindable_history_buffer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Rewindable history buffer assertion macros
// Clocked implication checks used by the history buffer control.
// ----------------------------------------------------------------------------
`ifndef REWINDABLE_HISTORY_BUFFER_CORE_MACROS_SVH
`define REWINDABLE_HISTORY_BUFFER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RHB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RHB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rhb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rewindable history buffer package
// Sizes, command and status codes, and the structs between the blocks.
// ----------------------------------------------------------------------------
package rhb_pkg;

  localparam int unsigned DEPTH  = 65536;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned OFS_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ST_W   = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [PTR_W:0]    span_t;
  typedef logic [OFS_W-1:0]  ofs_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam span_t DEPTH_SPAN = span_t'(DEPTH);
  localparam ptr_t  LAST_PTR   = ptr_t'(DEPTH - 1);
  localparam cnt_t  CNT_MAX    = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_UNGET = 2'd1,
    CMD_SEEK  = 2'd2
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EOS     = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  typedef struct packed {
    logic  we;
    ptr_t  addr;
    byte_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic    done;
    status_e status;
    logic    rd_ok;
    logic    bypass;
    byte_t   src;
    ofs_t    offset;
    cnt_t    unread;
  } result_t;

endpackage

// ===== design/rhb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rewindable history buffer RAM
// Single-port byte store with registered read, read-before-write.
// ----------------------------------------------------------------------------
module rhb_ram #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rhb_ctrl.sv =====
`timescale 1ns / 1ps
`include "rewindable_history_buffer_core_macros.svh"
// ----------------------------------------------------------------------------
// Rewindable history buffer control
// Pointer and offset state, command decode and result register.
// ----------------------------------------------------------------------------
module rhb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            command_i,
  input  logic [7:0]            source_byte_i,
  input  logic                  source_empty_i,
  input  logic [31:0]           target_offset_i,
  output logic                  busy_o,
  output rhb_pkg::mem_req_t     mem_req_o,
  output rhb_pkg::result_t      res_o
);
  import rhb_pkg::*;

  ptr_t    wp_q, wp_d, rp_q, rp_d;
  ofs_t    offset_q, offset_d;
  logic    busy_q;
  logic    done_q, rd_ok_q, rd_ok_d, byp_q, byp_d;
  status_e status_q, status_d;
  byte_t   src_q;
  logic    acc;
  logic    empty;
  span_t   unread_cur, avail;
  ptr_t    rp_next, rp_prev, rp_back;
  ofs_t    delta;
  logic    seek_ok;
  cnt_t    unread_sat;

  assign acc   = start_i && !busy_q;
  assign empty = (rp_q == wp_q);

  assign unread_cur = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
                                     : ({1'b0, wp_q} + DEPTH_SPAN - {1'b0, rp_q});
  assign avail   = DEPTH_SPAN - unread_cur;
  assign rp_next = (rp_q == LAST_PTR) ? '0 : rp_q + ptr_t'(1);
  assign rp_prev = (rp_q == '0) ? LAST_PTR : rp_q - ptr_t'(1);
  assign delta   = offset_q - target_offset_i;
  assign seek_ok = (target_offset_i <= offset_q) && (delta < OFS_W'(avail));
  assign rp_back = (OFS_W'(rp_q) >= delta)
                 ? (rp_q - delta[PTR_W-1:0])
                 : ptr_t'({1'b0, rp_q} + DEPTH_SPAN - delta[PTR_W:0]);

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    offset_d  = offset_q;
    status_d  = ST_DONE;
    rd_ok_d   = 1'b0;
    byp_d     = 1'b0;
    mem_req_o = '{we: 1'b0, addr: rp_q, wdata: source_byte_i};
    if (acc) begin
      case (command_i)
        CMD_READ: begin
          if (empty && source_empty_i) begin
            status_d = ST_EOS;
          end else begin
            if (empty) begin
              mem_req_o.we = 1'b1;
              wp_d         = rp_next;
            end
            byp_d    = empty;
            rd_ok_d  = 1'b1;
            rp_d     = rp_next;
            offset_d = offset_q + ofs_t'(1);
          end
        end
        CMD_UNGET: begin
          if ((offset_q == '0) || (unread_cur >= DEPTH_SPAN - span_t'(1))) begin
            status_d = ST_REFUSED;
          end else begin
            rp_d     = rp_prev;
            offset_d = offset_q - ofs_t'(1);
          end
        end
        CMD_SEEK: begin
          if (seek_ok) begin
            rp_d     = rp_back;
            offset_d = target_offset_i;
          end else begin
            status_d = ST_REFUSED;
          end
        end
        default: begin
          status_d = ST_REFUSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      offset_q <= '0;
      busy_q   <= 1'b1;
      done_q   <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      offset_q <= offset_d;
      busy_q   <= 1'b0;
      done_q   <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rd_ok_q  <= rd_ok_d;
    byp_q    <= byp_d;
    src_q    <= source_byte_i;
  end

  assign unread_sat = (OFS_W'(unread_cur) > OFS_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(unread_cur);

  assign busy_o = busy_q;
  assign res_o  = '{done: done_q, status: status_q, rd_ok: rd_ok_q, bypass: byp_q,
                    src: src_q, offset: offset_q, unread: unread_sat};

  `RHB_ASSERT_NXT(a_done_follows_accept, acc, done_q, "result strobe missing after accept")
  `RHB_ASSERT_NXT(a_no_spurious_done, !acc, !done_q, "result strobe without accept")
  `RHB_ASSERT_NXT(a_eos_holds_state,
    acc && (command_i == CMD_READ) && empty && source_empty_i,
    (status_q == ST_EOS) && $stable(offset_q) && $stable(rp_q) && $stable(wp_q),
    "end of stream changed state")
  `RHB_ASSERT_NXT(a_unget_at_start,
    acc && (command_i == CMD_UNGET) && (offset_q == '0),
    (status_q == ST_REFUSED) && $stable(rp_q),
    "unget at stream start not refused")
  `RHB_ASSERT_IMP(a_read_ok_is_done, done_q && rd_ok_q, status_q == ST_DONE,
    "delivered byte with bad status")

endmodule

// ===== design/rewindable_history_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rewindable history buffer core
// Byte ring that keeps consumed bytes for unget and seek back.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a word by raising start_i with command_i, source_byte_i,
//   source_empty_i and target_offset_i; it is taken on an edge where busy_o
//   is low. Commands: read next byte, unget one byte, seek to an offset.
//   Exactly one result word follows, in the cycle after the accept, marked by
//   done_o for one cycle with data_byte_o, status_o, stream_offset_o and
//   unread_count_o.
//   Throughput is one word per cycle; the single-port history RAM is read
//   once per command and written only by a read on an empty ring.
//   A read on an empty ring writes source_byte_i and returns it directly.
//   Reset clears the pointers and the offset and holds busy_o high until the
//   first clock edge after release; the RAM content is not cleared and is
//   never read before written.
//   The receiver cannot stall; results must be taken when done_o is high.
// ----------------------------------------------------------------------------
module rewindable_history_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  source_byte_i,
  input  logic        source_empty_i,
  input  logic [31:0] target_offset_i,
  output logic        done_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  status_o,
  output logic [31:0] stream_offset_o,
  output logic [15:0] unread_count_o
);
  import rhb_pkg::*;

  mem_req_t mem_req;
  result_t  res;
  byte_t    rdata;

  rhb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .command_i       (command_i),
    .source_byte_i   (source_byte_i),
    .source_empty_i  (source_empty_i),
    .target_offset_i (target_offset_i),
    .busy_o          (busy_o),
    .mem_req_o       (mem_req),
    .res_o           (res)
  );

  rhb_ram #(
    .ADDR_W (PTR_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  assign done_o          = res.done;
  assign data_byte_o     = !res.rd_ok ? '0 : (res.bypass ? res.src : rdata);
  assign status_o        = res.status;
  assign stream_offset_o = res.offset;
  assign unread_count_o  = res.unread;

endmodule

// ===== tb/rewindable_history_buffer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rewindable history buffer core testbench
// Drives read, unget, seek and unused commands through the start/busy port.
// A scoreboard keeps its own copy of the ring, pointers and offset, predicts
// every result word and compares it field by field as done_o marks it. A run
// of plain reads builds history ahead of deep and out-of-range seeks.
// ----------------------------------------------------------------------------
import rhb_pkg::*;

class rhb_history_scoreboard;

  typedef struct {
    byte_t   data;
    status_e status;
    ofs_t    offset;
    cnt_t    unread;
  } rhb_word_t;

  byte_t       hist [DEPTH];
  int unsigned wr_pos;
  int unsigned rd_pos;
  ofs_t        ofs;
  rhb_word_t   expected_q [$];
  int unsigned errors;
  int unsigned words;
  int unsigned reads;
  int unsigned ends;
  int unsigned ungets;
  int unsigned seeks;
  int unsigned refusals;
  int unsigned peak_unread;

  function new();
    wr_pos      = 0;
    rd_pos      = 0;
    ofs         = '0;
    errors      = 0;
    words       = 0;
    reads       = 0;
    ends        = 0;
    ungets      = 0;
    seeks       = 0;
    refusals    = 0;
    peak_unread = 0;
  endfunction

  function int unsigned unread();
    if (wr_pos >= rd_pos) return wr_pos - rd_pos;
    return wr_pos + DEPTH - rd_pos;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void note_word(logic [1:0] cmd, byte_t src, logic src_empty, ofs_t tgt);
    rhb_word_t   w;
    int unsigned n;
    int unsigned delta;
    w.data   = '0;
    w.status = ST_DONE;
    words++;
    case (cmd)
      CMD_READ: begin
        if (rd_pos == wr_pos && src_empty) begin
          w.status = ST_EOS;
          ends++;
        end else begin
          if (rd_pos == wr_pos) begin
            hist[wr_pos] = src;
            wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
          end
          w.data = hist[rd_pos];
          rd_pos = (rd_pos + 1 >= DEPTH) ? 0 : rd_pos + 1;
          ofs    = ofs + 1;
          reads++;
        end
      end
      CMD_UNGET: begin
        if (ofs == 0 || unread() >= DEPTH - 1) begin
          w.status = ST_REFUSED;
        end else begin
          rd_pos = (rd_pos == 0) ? DEPTH - 1 : rd_pos - 1;
          ofs    = ofs - 1;
          ungets++;
        end
      end
      CMD_SEEK: begin
        delta = ofs - tgt;
        if (tgt > ofs || delta >= DEPTH - unread()) begin
          w.status = ST_REFUSED;
        end else begin
          rd_pos = (rd_pos >= delta) ? rd_pos - delta : rd_pos + DEPTH - delta;
          ofs    = tgt;
          seeks++;
        end
      end
      default: begin
        w.status = ST_REFUSED;
      end
    endcase
    if (w.status == ST_REFUSED) refusals++;
    n = unread();
    if (n > peak_unread) peak_unread = n;
    w.offset = ofs;
    w.unread = (n > 32'hFFFF) ? CNT_MAX : cnt_t'(n);
    expected_q.push_back(w);
  endfunction

  function void check_result(byte_t data, logic [1:0] status, ofs_t offset, cnt_t unr);
    rhb_word_t w;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word, data %02h status %0d offset %0d unread %0d",
               $time, data, status, offset, unr);
      errors++;
      return;
    end
    w = expected_q.pop_front();
    if (data !== w.data) begin
      $display("%0t: data_byte expected %02h, got %02h", $time, w.data, data);
      errors++;
    end
    if (status !== w.status) begin
      $display("%0t: status expected %0d, got %0d", $time, w.status, status);
      errors++;
    end
    if (offset !== w.offset) begin
      $display("%0t: stream_offset expected %0d, got %0d", $time, w.offset, offset);
      errors++;
    end
    if (unr !== w.unread) begin
      $display("%0t: unread_count expected %0d, got %0d", $time, w.unread, unr);
      errors++;
    end
  endfunction

endclass

module rewindable_history_buffer_core_test;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned BULK_READS   = 256;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned CALM_WORDS   = 300;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  command_i;
  logic [7:0]  source_byte_i;
  logic        source_empty_i;
  logic [31:0] target_offset_i;
  logic        done_o;
  logic [7:0]  data_byte_o;
  logic [1:0]  status_o;
  logic [31:0] stream_offset_o;
  logic [15:0] unread_count_o;

  rhb_history_scoreboard history;
  int unsigned           cycles = 0;
  bit                    calm   = 1'b0;

  rewindable_history_buffer_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .source_byte_i   (source_byte_i),
    .source_empty_i  (source_empty_i),
    .target_offset_i (target_offset_i),
    .done_o          (done_o),
    .data_byte_o     (data_byte_o),
    .status_o        (status_o),
    .stream_offset_o (stream_offset_o),
    .unread_count_o  (unread_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        history.note_word(command_i, source_byte_i, source_empty_i, target_offset_i);
      end
      if (done_o) begin
        history.check_result(data_byte_o, status_o, stream_offset_o, unread_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input byte_t src, input logic src_empty,
                           input ofs_t tgt);
    start_i         <= 1'b1;
    command_i       <= cmd;
    source_byte_i   <= src;
    source_empty_i  <= src_empty;
    target_offset_i <= tgt;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic rest(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (history.pending() != 0);
  endtask

  task automatic random_word();
    int unsigned pick;
    int unsigned back;
    ofs_t        tgt;
    pick = $urandom_range(0, 99);
    tgt  = $urandom;
    if (pick < 55) begin
      send_word(CMD_READ, byte_t'($urandom), $urandom_range(0, 9) == 0, tgt);
    end else if (pick < 70) begin
      send_word(CMD_UNGET, byte_t'($urandom), 1'($urandom), tgt);
    end else if (pick < 92) begin
      back = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 48);
      if ($urandom_range(0, 9) == 0) tgt = history.ofs + $urandom_range(1, 3);
      else tgt = history.ofs - back;
      send_word(CMD_SEEK, byte_t'($urandom), 1'($urandom), tgt);
    end else if (pick < 97) begin
      send_word(CMD_SEEK, byte_t'($urandom), 1'($urandom), tgt);
    end else begin
      send_word(CMD_UNUSED, byte_t'($urandom), 1'($urandom), tgt);
    end
    if (!calm && $urandom_range(0, 7) == 0) rest($urandom_range(1, 19));
  endtask

  initial begin
    history         = new();
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    command_i       = CMD_READ;
    source_byte_i   = '0;
    source_empty_i  = 1'b0;
    target_offset_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(CMD_UNGET, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_word(CMD_READ, 8'hFF, 1'b1, 32'h0000_0000);
    send_word(CMD_SEEK, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_SEEK, 8'h00, 1'b0, 32'h0000_0001);
    send_word(CMD_SEEK, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_word(CMD_READ, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_word(CMD_READ, 8'hFF, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 8'hA5, 1'b0, 32'hAAAA_AAAA);
    send_word(CMD_READ, 8'h5A, 1'b0, 32'h5555_5555);
    send_word(CMD_UNGET, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 8'hFF, 1'b1, 32'h0000_0000);
    send_word(CMD_UNGET, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_UNGET, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_SEEK, 8'h00, 1'b0, 32'h0000_0004);
    send_word(CMD_SEEK, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 8'h11, 1'b1, 32'h0000_0000);
    send_word(CMD_READ, 8'h22, 1'b1, 32'h0000_0000);
    send_word(CMD_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_word(CMD_SEEK, 8'h00, 1'b0, 32'h0000_0002);
    send_word(CMD_UNGET, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 8'h3C, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 8'h3C, 1'b1, 32'h0000_0000);
    send_word(CMD_READ, 8'hC3, 1'b1, 32'h0000_0000);
    send_word(CMD_READ, 8'hC3, 1'b1, 32'h0000_0000);
    send_word(CMD_READ, 8'h81, 1'b0, 32'h0000_0000);

    repeat (RANDOM_WORDS / 2) random_word();
    drain();

    repeat (BULK_READS) send_word(CMD_READ, byte_t'($urandom), 1'b0, ofs_t'($urandom));
    send_word(CMD_SEEK, 8'h00, 1'b0, history.ofs - ofs_t'(DEPTH - 1 - history.unread()));
    send_word(CMD_UNGET, 8'h00, 1'b0, 32'h0000_0000);
    send_word(CMD_SEEK, 8'h00, 1'b0, history.ofs - 1);
    send_word(CMD_SEEK, 8'h00, 1'b0, history.ofs);
    repeat (3) send_word(CMD_READ, byte_t'($urandom), 1'b1, 32'h0000_0000);
    send_word(CMD_SEEK, 8'h00, 1'b0, history.ofs - 3);

    repeat (RANDOM_WORDS / 2 - CALM_WORDS) random_word();
    calm = 1'b1;
    repeat (CALM_WORDS) random_word();
    drain();
    repeat (4) @(posedge clk_i);

    $display("%0d words: %0d reads, %0d end of stream, %0d ungets, %0d seeks, %0d refused",
             history.words, history.reads, history.ends, history.ungets, history.seeks,
             history.refusals);
    $display("peak unread %0d bytes, final stream offset %0d, %0d mismatches",
             history.peak_unread, history.ofs, history.errors);
    if (history.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
